>>> rtl/hwhc_pkg.sv
// ----------------------------------------------------------------------------
// hwhc_pkg
// Shared constants for the hop witness hash chain: FNV-1a 32 constants,
// message length, status codes, config register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package hwhc_pkg;

    // FNV-1a 32 constants
    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

    // message per hop: witness(4) hop(4) carrier orient scope layer(2) inversion
    localparam int FNV_BYTES   = 14;
    localparam int MSG_W       = FNV_BYTES * 8;
    localparam int BYTE_CNT_W  = $clog2(FNV_BYTES);

    // parameter defaults
    localparam int MAX_HOPS_DEF      = 32;
    localparam int CARRIER_TOTAL_DEF = 8;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_CARRIER = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROOT_WITNESS    = 2'd0;
    localparam logic [1:0] CFG_START_LAYER     = 2'd1;
    localparam logic [1:0] CFG_START_INVERSION = 2'd2;

endpackage

>>> rtl/hwhc_fnv_unit.sv
// ----------------------------------------------------------------------------
// hwhc_fnv_unit
// Byte-serial FNV-1a 32 engine: the message sits in a shift register and
// one byte is folded into the hash per cycle, low byte first.
// ----------------------------------------------------------------------------
module hwhc_fnv_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hwhc_pkg::MSG_W-1:0] msg,
    output logic                      done,
    output logic [31:0]               hash
);

    localparam logic [hwhc_pkg::BYTE_CNT_W-1:0] LAST_BYTE =
        hwhc_pkg::BYTE_CNT_W'(hwhc_pkg::FNV_BYTES - 1);

    logic                               busy_reg;
    logic                               done_reg;
    logic [hwhc_pkg::BYTE_CNT_W-1:0]    cnt_reg;
    logic [hwhc_pkg::MSG_W-1:0]         msg_reg;
    logic [31:0]                        hash_reg;
    logic [31:0]                        hash_next;

    // one FNV-1a step on the current low byte
    always_comb
    begin
        hash_next = 32'((hash_reg ^ {24'd0, msg_reg[7:0]}) * hwhc_pkg::FNV_PRIME);
    end

    // control: busy until the last byte is counted, then a done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_BYTE)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // datapath: message shifts down a byte per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hash_reg <= hwhc_pkg::FNV_BASIS;
            msg_reg  <= msg;
        end
        else if (busy_reg)
        begin
            hash_reg <= hash_next;
            msg_reg  <= {8'd0, msg_reg[hwhc_pkg::MSG_W-1:8]};
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

>>> rtl/hop_witness_hash_chain_top.sv
// ----------------------------------------------------------------------------
// hop_witness_hash_chain_top
// Chained FNV-1a 32 witness over routing hops with restart from config.
// ----------------------------------------------------------------------------
// An append that passes checks is hashed byte by byte in the serial FNV unit;
//   its hash is taken into the pending result and committed to the result beat.
// Restart and rejected appends go from accept straight to the done state.
// One item in flight: input stalls from accept until the result is committed,
//   and a commit waits while the output beat is stalled.
// Reset (rst_n, async low) clears chain witness, hop count, held layer and
//   inversion and the config registers; no clearing pass.
module hop_witness_hash_chain_top
#(
    parameter int MAX_HOPS      = hwhc_pkg::MAX_HOPS_DEF,
    parameter int CARRIER_TOTAL = hwhc_pkg::CARRIER_TOTAL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [31:0]        hop_id,
    input  logic [7:0]         carrier_sel,
    input  logic [7:0]         orient,
    input  logic [7:0]         scope_level,
    input  logic               clock_present,
    input  logic signed [15:0] clock_layer,
    input  logic [7:0]         clock_inversion,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         entry_index,
    output logic [31:0]        witness_prev,
    output logic [31:0]        witness_next,
    output logic signed [15:0] used_layer,
    output logic [7:0]         used_inversion
);

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_HASH = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam logic [7:0] HOP_LIMIT     = 8'(MAX_HOPS);
    localparam logic [8:0] CARRIER_LIMIT = 9'(CARRIER_TOTAL);

    // config registers
    logic [31:0]        root_witness_reg;
    logic signed [15:0] start_layer_reg;
    logic [7:0]         start_inv_reg;

    // chain state
    logic [31:0]        chain_witness_reg;
    logic [7:0]         hop_total_reg;
    logic signed [15:0] held_layer_reg;
    logic [7:0]         held_inv_reg;

    // pending result
    state_t             state_reg;
    state_t             state_next;
    logic               pend_restart_reg;
    logic               pend_append_reg;
    logic [1:0]         pend_status_reg;
    logic [7:0]         pend_index_reg;
    logic [31:0]        pend_prev_reg;
    logic [31:0]        pend_next_reg;
    logic signed [15:0] pend_layer_reg;
    logic [7:0]         pend_inv_reg;

    // output registers
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [7:0]         entry_index_reg;
    logic [31:0]        witness_prev_reg;
    logic [31:0]        witness_next_reg;
    logic signed [15:0] used_layer_reg;
    logic [7:0]         used_inv_reg;

    logic               in_beat;
    logic               out_free;
    logic               commit;
    logic               chain_full;
    logic               carrier_bad;
    logic signed [15:0] sel_layer;
    logic [7:0]         sel_inv;
    logic               fnv_start;
    logic               fnv_done;
    logic [31:0]        fnv_hash;
    logic [hwhc_pkg::MSG_W-1:0] fnv_msg;

    assign in_stall = (state_reg != S_IDLE);
    assign in_beat  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_DONE) && out_free;

    // item checks and layer/inversion selection
    assign chain_full  = (hop_total_reg >= HOP_LIMIT);
    assign carrier_bad = ({1'b0, carrier_sel} >= CARRIER_LIMIT);
    assign sel_layer   = clock_present ? clock_layer : held_layer_reg;
    assign sel_inv     = clock_present ? clock_inversion : held_inv_reg;
    assign fnv_start   = in_beat && !action && !chain_full && !carrier_bad;

    // message, low byte hashed first
    assign fnv_msg = {sel_inv, sel_layer, scope_level, orient, carrier_sel,
                      hop_id, chain_witness_reg};

    hwhc_fnv_unit u_fnv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fnv_start),
        .msg   (fnv_msg),
        .done  (fnv_done),
        .hash  (fnv_hash)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = fnv_start ? S_HASH : S_DONE;
                end
            end
            S_HASH:
            begin
                if (fnv_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, config and chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            pend_restart_reg  <= 1'b0;
            pend_append_reg   <= 1'b0;
            root_witness_reg  <= '0;
            start_layer_reg   <= '0;
            start_inv_reg     <= '0;
            chain_witness_reg <= '0;
            hop_total_reg     <= '0;
            held_layer_reg    <= '0;
            held_inv_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // config writes; unknown indexes are ignored
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hwhc_pkg::CFG_ROOT_WITNESS:    root_witness_reg <= cfg_data;
                    hwhc_pkg::CFG_START_LAYER:     start_layer_reg  <= cfg_data[15:0];
                    hwhc_pkg::CFG_START_INVERSION: start_inv_reg    <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_beat)
            begin
                pend_restart_reg <= action;
                pend_append_reg  <= fnv_start;
            end

            // output beat handshake
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // chain advance on commit
            if (commit && pend_restart_reg)
            begin
                chain_witness_reg <= pend_next_reg;
                hop_total_reg     <= '0;
                held_layer_reg    <= pend_layer_reg;
                held_inv_reg      <= pend_inv_reg;
            end
            else if (commit && pend_append_reg)
            begin
                chain_witness_reg <= pend_next_reg;
                hop_total_reg     <= hop_total_reg + 1'b1;
                held_layer_reg    <= pend_layer_reg;
                held_inv_reg      <= pend_inv_reg;
            end
        end
    end

    // pending result capture
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pend_prev_reg <= chain_witness_reg;
            if (action)
            begin
                pend_status_reg <= hwhc_pkg::STATUS_OK;
                pend_index_reg  <= '0;
                pend_next_reg   <= root_witness_reg;
                pend_layer_reg  <= start_layer_reg;
                pend_inv_reg    <= start_inv_reg;
            end
            else
            begin
                pend_index_reg <= hop_total_reg;
                pend_next_reg  <= chain_witness_reg;
                pend_layer_reg <= sel_layer;
                pend_inv_reg   <= sel_inv;
                if (chain_full)
                begin
                    pend_status_reg <= hwhc_pkg::STATUS_FULL;
                end
                else if (carrier_bad)
                begin
                    pend_status_reg <= hwhc_pkg::STATUS_CARRIER;
                end
                else
                begin
                    pend_status_reg <= hwhc_pkg::STATUS_OK;
                end
            end
        end
        else if ((state_reg == S_HASH) && fnv_done)
        begin
            pend_next_reg <= fnv_hash;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg       <= pend_status_reg;
            entry_index_reg  <= pend_index_reg;
            witness_prev_reg <= pend_prev_reg;
            witness_next_reg <= pend_next_reg;
            used_layer_reg   <= pend_layer_reg;
            used_inv_reg     <= pend_inv_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_index    = entry_index_reg;
    assign witness_prev   = witness_prev_reg;
    assign witness_next   = witness_next_reg;
    assign used_layer     = used_layer_reg;
    assign used_inversion = used_inv_reg;

    // checks
    a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        fnv_done |-> (state_reg == S_HASH))
        else $error("hash unit finished outside hash state");

    a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hop_total_reg <= HOP_LIMIT)
        else $error("hop count beyond limit");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside commit");

    a_reject_keeps_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != hwhc_pkg::STATUS_OK))
            |-> (witness_prev_reg == witness_next_reg))
        else $error("rejected hop changed the witness");

endmodule
